// ----- rtl/btpa_pkg.sv -----
// Package for the boundary-tag pool allocator: widths, codes, command type.
// Used by every module under rtl/; depends on nothing.
`default_nettype none
package btpa_pkg;
   localparam int POOL_WORDS      = 4096;
   localparam int MIN_BLOCK_WORDS = 4;
   localparam int QUEUE_DEPTH     = 2;
   localparam int ADDR_W          = 12;   // word index into the store
   localparam int PTR_W           = 13;   // list pointer, top bit set means null
   localparam int SIZE_W          = 13;   // sizes and counts in words
   localparam int WIDE_W          = 14;   // sizes before the fit check, tag words
   localparam int FRAG_W          = 11;
   localparam int TAG_FLAG_BIT    = 13;   // allocated flag inside a tag word

   localparam logic [PTR_W-1:0]  NIL_PTR    = 13'h1FFF;
   localparam logic [SIZE_W-1:0] POOL_RESET = 13'd4096;
   localparam logic [FRAG_W-1:0] FRAG_MAX   = 11'h7FF;

   localparam logic ACT_ALLOC = 1'b0;
   localparam logic ACT_FREE  = 1'b1;

   localparam logic [1:0] STAT_OK      = 2'd0;
   localparam logic [1:0] STAT_NOSPACE = 2'd1;
   localparam logic [1:0] STAT_BADFREE = 2'd2;

   typedef struct packed {
      logic                    is_free;
      logic [WIDE_W-1:0]       size;     // block size with tags, floor applied
      logic [ADDR_W-1:0]       fa;       // payload start word for a free
   } cmd_type;
endpackage
`default_nettype wire

// ----- rtl/btpa_front.sv -----
// Front end: take request transactions and turn them into engine commands.
// Depends on btpa_pkg.
`default_nettype none
module btpa_front #(
   parameter int MIN_BLOCK_WORDS = btpa_pkg::MIN_BLOCK_WORDS
) (
   input  wire logic              in_valid,
   output logic                   in_ready,
   input  wire logic              in_action,
   input  wire logic [12:0]       in_req_words,
   input  wire logic [11:0]       in_free_addr,
   output logic                   push,
   output btpa_pkg::cmd_type      cmd,
   input  wire logic              q_full
);
   logic [btpa_pkg::WIDE_W-1:0] raw_size;

   // add header and trailer, then raise to the minimum block
   assign raw_size = {1'b0, in_req_words} + btpa_pkg::WIDE_W'(2);
   assign in_ready = !q_full;
   assign push     = in_valid && !q_full;

   always_comb begin
      cmd.is_free = (in_action == btpa_pkg::ACT_FREE);
      cmd.fa      = in_free_addr;
      if (raw_size < btpa_pkg::WIDE_W'(MIN_BLOCK_WORDS)) begin
         cmd.size = btpa_pkg::WIDE_W'(MIN_BLOCK_WORDS);
      end else begin
         cmd.size = raw_size;
      end
   end
endmodule
`default_nettype wire

// ----- rtl/btpa_queue.sv -----
// Short command queue between front end and engine.
// Depends on btpa_pkg.
`default_nettype none
module btpa_queue #(
   parameter int DEPTH = btpa_pkg::QUEUE_DEPTH
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire btpa_pkg::cmd_type push_cmd,
   output logic                   full,
   input  wire logic              pop,
   output logic                   valid,
   output btpa_pkg::cmd_type      head_cmd
);
   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   btpa_pkg::cmd_type slot_ff [DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [PW:0]   count_ff, count_in;
   logic          do_push, do_pop;

   assign full     = (count_ff == (PW+1)'(DEPTH));
   assign valid    = (count_ff != '0);
   assign head_cmd = slot_ff[rd_ptr_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH-1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH-1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + (PW+1)'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - (PW+1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end
endmodule
`default_nettype wire

// ----- rtl/btpa_engine.sv -----
// Back end: sequencer over the tag store and the free-list link stores,
// plus the result register. Depends on btpa_pkg.
`default_nettype none
module btpa_engine #(
   parameter int MIN_BLOCK_WORDS = btpa_pkg::MIN_BLOCK_WORDS
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic [12:0]       pool_words,
   input  wire logic              q_valid,
   input  wire btpa_pkg::cmd_type q_cmd,
   output logic                   pop,
   output logic                   out_valid,
   input  wire logic              out_ready,
   output logic [1:0]             out_status,
   output logic [11:0]            out_addr,
   output logic [12:0]            out_block_words,
   output logic [12:0]            out_used_words,
   output logic [10:0]            out_free_fragments,
   output logic [12:0]            out_high_mark
);
   localparam int AW = btpa_pkg::ADDR_W;
   localparam int PW = btpa_pkg::PTR_W;
   localparam int SW = btpa_pkg::SIZE_W;
   localparam int WW = btpa_pkg::WIDE_W;
   localparam int FW = btpa_pkg::FRAG_W;
   localparam int FB = btpa_pkg::TAG_FLAG_BIT;
   localparam logic [WW-1:0] MINW = WW'(MIN_BLOCK_WORDS);

   typedef enum logic [17:0] {
      S_IDLE    = 18'h00001,
      S_A_WALK  = 18'h00002,
      S_A_CHK   = 18'h00004,
      S_A_BUMP  = 18'h00008,
      S_F_T0    = 18'h00010,
      S_F_T1    = 18'h00020,
      S_F_P     = 18'h00040,
      S_F_N     = 18'h00080,
      S_F_NC    = 18'h00100,
      S_F_MERGE = 18'h00200,
      S_F_WALK  = 18'h00400,
      S_F_WRD   = 18'h00800,
      S_F_X     = 18'h01000,
      S_LK_RD   = 18'h02000,
      S_LK_SET  = 18'h04000,
      S_LK_FIX  = 18'h08000,
      S_TAGW    = 18'h10000,
      S_DONE    = 18'h20000
   } state_type;

   state_type state_ff, state_in;

   // stores
   logic [WW-1:0] tag_mem  [btpa_pkg::POOL_WORDS];
   logic [PW-1:0] next_mem [btpa_pkg::POOL_WORDS];
   logic [PW-1:0] prev_mem [btpa_pkg::POOL_WORDS];
   logic [WW-1:0] tag_rd_ff;
   logic [PW-1:0] next_rd_ff, prev_rd_ff;
   logic [AW-1:0] tag_ra, next_ra, prev_ra, tag_wa, next_wa, prev_wa;
   logic [WW-1:0] tag_wd;
   logic [PW-1:0] next_wd, prev_wd;
   logic          tag_we, next_we, prev_we;

   // control state
   logic [PW-1:0] head_ff, head_in, tail_ff, tail_in;
   logic [SW-1:0] top_ff, top_in, alloc_ff, alloc_in;
   logic [FW-1:0] frag_ff, frag_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [2:0]    wq_cnt_ff, wq_cnt_in, wq_idx_ff, wq_idx_in;

   // working registers
   logic [WW-1:0] size_ff, size_in, tag_ff, tag_in, endb_ff, endb_in;
   logic [PW-1:0] node_ff, node_in, start_ff, start_in, w_ff, w_in;
   logic [PW-1:0] ln_ff, ln_in, lp_ff, lp_in, lx_ff, lx_in;
   logic [SW-1:0] k_ff, k_in, psize_ff, psize_in, nsize_ff, nsize_in;
   logic          pfree_ff, pfree_in, nfree_ff, nfree_in, splice_ff, splice_in;
   logic [1:0]    st_ff, st_in;
   logic [AW-1:0] raddr_ff, raddr_in;
   logic [SW-1:0] rbw_ff, rbw_in;
   logic [PW-1:0] wq_addr_ff [4];
   logic [PW-1:0] wq_addr_in [4];
   logic [WW-1:0] wq_data_ff [4];
   logic [WW-1:0] wq_data_in [4];
   logic [1:0]    o_status_ff;
   logic [11:0]   o_addr_ff;
   logic [12:0]   o_bw_ff, o_used_ff, o_top_ff;
   logic [10:0]   o_frag_ff;

   // combinational helpers
   logic [WW-1:0] fsize, rest, t_sum, merged;
   logic [SW-1:0] pool_end, bump_room;
   logic [PW-1:0] nstart;
   logic          load_out;

   assign pop       = (state_ff == S_IDLE) && q_valid;
   assign load_out  = (state_ff == S_DONE) && (!rsp_valid_ff || out_ready);
   assign pool_end  = (pool_words > btpa_pkg::POOL_RESET) ? btpa_pkg::POOL_RESET : pool_words;
   assign bump_room = pool_end - top_ff;
   assign fsize     = {1'b0, tag_rd_ff[SW-1:0]};
   assign rest      = fsize - size_ff;
   assign t_sum     = {1'b0, start_ff} + {1'b0, tag_rd_ff[SW-1:0]};
   assign nstart    = start_ff - psize_ff;

   always_comb begin
      merged = {1'b0, tag_ff[SW-1:0]};
      if (pfree_ff) begin
         merged = merged + {1'b0, psize_ff};
      end
      if (nfree_ff) begin
         merged = merged + {1'b0, nsize_ff};
      end
   end

   always_comb begin
      state_in = state_ff;
      head_in = head_ff; tail_in = tail_ff; top_in = top_ff; alloc_in = alloc_ff;
      frag_in = frag_ff; wq_cnt_in = wq_cnt_ff; wq_idx_in = wq_idx_ff;
      size_in = size_ff; tag_in = tag_ff; endb_in = endb_ff; node_in = node_ff;
      start_in = start_ff; w_in = w_ff; ln_in = ln_ff; lp_in = lp_ff; lx_in = lx_ff;
      k_in = k_ff; psize_in = psize_ff; nsize_in = nsize_ff; pfree_in = pfree_ff;
      nfree_in = nfree_ff; splice_in = splice_ff; st_in = st_ff; raddr_in = raddr_ff;
      rbw_in = rbw_ff;
      wq_addr_in = wq_addr_ff;
      wq_data_in = wq_data_ff;
      rsp_valid_in = rsp_valid_ff;
      tag_ra = '0; next_ra = '0; prev_ra = '0;
      tag_we = 1'b0; tag_wa = '0; tag_wd = '0;
      next_we = 1'b0; next_wa = '0; next_wd = '0;
      prev_we = 1'b0; prev_wa = '0; prev_wd = '0;

      if (rsp_valid_ff && out_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (q_valid) begin
               st_in     = btpa_pkg::STAT_OK;
               raddr_in  = '0;
               rbw_in    = '0;
               wq_cnt_in = '0;
               wq_idx_in = '0;
               size_in   = q_cmd.size;
               if (!q_cmd.is_free) begin
                  node_in  = head_ff;
                  k_in     = '0;
                  state_in = S_A_WALK;
               end else if (q_cmd.fa == '0) begin
                  st_in    = btpa_pkg::STAT_BADFREE;
                  state_in = S_DONE;
               end else begin
                  start_in = {1'b0, q_cmd.fa - AW'(1)};
                  tag_ra   = q_cmd.fa - AW'(1);
                  state_in = S_F_T0;
               end
            end
         end
         S_A_WALK: begin
            // walk the list in address order while entries remain
            if ((k_ff < {2'b0, frag_ff}) && !node_ff[PW-1]) begin
               tag_ra   = node_ff[AW-1:0];
               next_ra  = node_ff[AW-1:0];
               prev_ra  = node_ff[AW-1:0];
               state_in = S_A_CHK;
            end else begin
               state_in = S_A_BUMP;
            end
         end
         S_A_CHK: begin
            if (fsize >= size_ff) begin
               if (rest >= MINW) begin
                  // split: front stays free, hand out the tail
                  start_in = node_ff + rest[PW-1:0];
                  wq_addr_in[0] = node_ff;
                  wq_data_in[0] = {1'b0, rest[SW-1:0]};
                  wq_addr_in[1] = node_ff + rest[PW-1:0] - PW'(1);
                  wq_data_in[1] = {1'b0, rest[SW-1:0]};
                  wq_addr_in[2] = node_ff + rest[PW-1:0];
                  wq_data_in[2] = {1'b1, size_ff[SW-1:0]};
                  wq_addr_in[3] = node_ff + rest[PW-1:0] + size_ff[PW-1:0] - PW'(1);
                  wq_data_in[3] = {1'b1, size_ff[SW-1:0]};
                  wq_cnt_in = 3'd4;
                  alloc_in  = alloc_ff + size_ff[SW-1:0];
                  raddr_in  = node_ff[AW-1:0] + rest[AW-1:0] + AW'(1);
                  rbw_in    = size_ff[SW-1:0];
                  state_in  = S_TAGW;
               end else begin
                  // whole block: unlink it
                  wq_addr_in[0] = node_ff;
                  wq_data_in[0] = {1'b1, fsize[SW-1:0]};
                  wq_addr_in[1] = node_ff + fsize[PW-1:0] - PW'(1);
                  wq_data_in[1] = {1'b1, fsize[SW-1:0]};
                  wq_cnt_in = 3'd2;
                  alloc_in  = alloc_ff + fsize[SW-1:0];
                  raddr_in  = node_ff[AW-1:0] + AW'(1);
                  rbw_in    = fsize[SW-1:0];
                  if (frag_ff != '0) begin
                     frag_in = frag_ff - FW'(1);
                  end
                  lp_in     = prev_rd_ff;
                  lx_in     = next_rd_ff;
                  splice_in = 1'b0;
                  state_in  = S_LK_FIX;
               end
            end else begin
               node_in  = next_rd_ff;
               k_in     = k_ff + SW'(1);
               state_in = S_A_WALK;
            end
         end
         S_A_BUMP: begin
            if ((top_ff <= pool_end) && ({1'b0, bump_room} >= size_ff)) begin
               top_in   = top_ff + size_ff[SW-1:0];
               alloc_in = alloc_ff + size_ff[SW-1:0];
               wq_addr_in[0] = top_ff;
               wq_data_in[0] = {1'b1, size_ff[SW-1:0]};
               wq_addr_in[1] = top_ff + size_ff[PW-1:0] - PW'(1);
               wq_data_in[1] = {1'b1, size_ff[SW-1:0]};
               wq_cnt_in = 3'd2;
               raddr_in  = top_ff[AW-1:0] + AW'(1);
               rbw_in    = size_ff[SW-1:0];
               state_in  = S_TAGW;
            end else begin
               st_in    = btpa_pkg::STAT_NOSPACE;
               state_in = S_DONE;
            end
         end
         S_F_T0: begin
            tag_in  = tag_rd_ff;
            endb_in = t_sum;
            if ((fsize < MINW) || !tag_rd_ff[FB] || (t_sum > {1'b0, top_ff})) begin
               st_in    = btpa_pkg::STAT_BADFREE;
               state_in = S_DONE;
            end else begin
               tag_ra   = t_sum[AW-1:0] - AW'(1);
               state_in = S_F_T1;
            end
         end
         S_F_T1: begin
            if (tag_rd_ff != tag_ff) begin
               st_in    = btpa_pkg::STAT_BADFREE;
               state_in = S_DONE;
            end else begin
               rbw_in   = tag_ff[SW-1:0];
               pfree_in = 1'b0;
               if (start_ff != '0) begin
                  tag_ra   = start_ff[AW-1:0] - AW'(1);
                  state_in = S_F_P;
               end else begin
                  state_in = S_F_N;
               end
            end
         end
         S_F_P: begin
            psize_in = tag_rd_ff[SW-1:0];
            pfree_in = !tag_rd_ff[FB] && (fsize >= MINW) && (tag_rd_ff[SW-1:0] <= start_ff);
            state_in = S_F_N;
         end
         S_F_N: begin
            nfree_in = 1'b0;
            if (endb_ff != {1'b0, top_ff}) begin
               tag_ra   = endb_ff[AW-1:0];
               state_in = S_F_NC;
            end else begin
               state_in = S_F_MERGE;
            end
         end
         S_F_NC: begin
            nsize_in = tag_rd_ff[SW-1:0];
            nfree_in = !tag_rd_ff[FB] && (fsize >= MINW)
                       && (tag_rd_ff[SW-1:0] <= (top_ff - endb_ff[SW-1:0]));
            state_in = S_F_MERGE;
         end
         S_F_MERGE: begin
            alloc_in = (alloc_ff >= tag_ff[SW-1:0]) ? alloc_ff - tag_ff[SW-1:0] : '0;
            splice_in = 1'b0;
            if (endb_ff == {1'b0, top_ff}) begin
               // end block: drop the top mark, absorb a free block below
               if (pfree_ff) begin
                  top_in  = nstart;
                  ln_in   = nstart;
                  next_ra = nstart[AW-1:0];
                  prev_ra = nstart[AW-1:0];
                  if (frag_ff != '0) begin
                     frag_in = frag_ff - FW'(1);
                  end
                  state_in = S_LK_RD;
               end else begin
                  top_in   = start_ff;
                  state_in = S_DONE;
               end
            end else begin
               wq_addr_in[0] = pfree_ff ? nstart : start_ff;
               wq_data_in[0] = {1'b0, merged[SW-1:0]};
               wq_addr_in[1] = (pfree_ff ? nstart : start_ff) + merged[PW-1:0] - PW'(1);
               wq_data_in[1] = {1'b0, merged[SW-1:0]};
               wq_cnt_in = 3'd2;
               if (pfree_ff) begin
                  start_in = nstart;
                  if (nfree_ff) begin
                     next_ra = endb_ff[AW-1:0];
                     prev_ra = endb_ff[AW-1:0];
                     if (frag_ff != '0) begin
                        frag_in = frag_ff - FW'(1);
                     end
                     state_in = S_LK_RD;
                  end else begin
                     state_in = S_TAGW;
                  end
               end else if (nfree_ff) begin
                  // take over the list slot of the block above
                  ln_in     = start_ff;
                  splice_in = 1'b1;
                  next_ra   = endb_ff[AW-1:0];
                  prev_ra   = endb_ff[AW-1:0];
                  state_in  = S_LK_RD;
               end else begin
                  w_in      = tail_ff;
                  k_in      = '0;
                  ln_in     = start_ff;
                  splice_in = 1'b1;
                  if (frag_ff != btpa_pkg::FRAG_MAX) begin
                     frag_in = frag_ff + FW'(1);
                  end
                  state_in = S_F_WALK;
               end
            end
         end
         S_F_WALK: begin
            // step back from the tail to the insertion point
            if (!w_ff[PW-1] && (w_ff > start_ff) && (k_ff < btpa_pkg::POOL_RESET)) begin
               prev_ra  = w_ff[AW-1:0];
               state_in = S_F_WRD;
            end else if (!w_ff[PW-1]) begin
               next_ra  = w_ff[AW-1:0];
               state_in = S_F_X;
            end else begin
               lx_in    = head_ff;
               lp_in    = btpa_pkg::NIL_PTR;
               state_in = S_LK_SET;
            end
         end
         S_F_WRD: begin
            w_in     = prev_rd_ff;
            k_in     = k_ff + SW'(1);
            state_in = S_F_WALK;
         end
         S_F_X: begin
            lx_in    = next_rd_ff;
            lp_in    = w_ff;
            state_in = S_LK_SET;
         end
         S_LK_RD: begin
            lp_in    = prev_rd_ff;
            lx_in    = next_rd_ff;
            state_in = splice_ff ? S_LK_SET : S_LK_FIX;
         end
         S_LK_SET: begin
            next_we  = !ln_ff[PW-1];
            next_wa  = ln_ff[AW-1:0];
            next_wd  = lx_ff;
            prev_we  = !ln_ff[PW-1];
            prev_wa  = ln_ff[AW-1:0];
            prev_wd  = lp_ff;
            state_in = S_LK_FIX;
         end
         S_LK_FIX: begin
            if (!lp_ff[PW-1]) begin
               next_we = 1'b1;
               next_wa = lp_ff[AW-1:0];
               next_wd = splice_ff ? ln_ff : lx_ff;
            end else begin
               head_in = splice_ff ? ln_ff : lx_ff;
            end
            if (!lx_ff[PW-1]) begin
               prev_we = 1'b1;
               prev_wa = lx_ff[AW-1:0];
               prev_wd = splice_ff ? ln_ff : lp_ff;
            end else begin
               tail_in = splice_ff ? ln_ff : lp_ff;
            end
            state_in = S_TAGW;
         end
         S_TAGW: begin
            if (wq_idx_ff < wq_cnt_ff) begin
               tag_we    = !wq_addr_ff[wq_idx_ff[1:0]][PW-1];
               tag_wa    = wq_addr_ff[wq_idx_ff[1:0]][AW-1:0];
               tag_wd    = wq_data_ff[wq_idx_ff[1:0]];
               wq_idx_in = wq_idx_ff + 3'd1;
            end else begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (load_out) begin
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= btpa_pkg::NIL_PTR;
         tail_ff      <= btpa_pkg::NIL_PTR;
         top_ff       <= '0;
         alloc_ff     <= '0;
         frag_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         wq_cnt_ff    <= '0;
         wq_idx_ff    <= '0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         top_ff       <= top_in;
         alloc_ff     <= alloc_in;
         frag_ff      <= frag_in;
         rsp_valid_ff <= rsp_valid_in;
         wq_cnt_ff    <= wq_cnt_in;
         wq_idx_ff    <= wq_idx_in;
      end
   end

   always_ff @(posedge clock) begin
      size_ff <= size_in;   tag_ff <= tag_in;     endb_ff <= endb_in;
      node_ff <= node_in;   start_ff <= start_in; w_ff <= w_in;
      ln_ff <= ln_in;       lp_ff <= lp_in;       lx_ff <= lx_in;
      k_ff <= k_in;         psize_ff <= psize_in; nsize_ff <= nsize_in;
      pfree_ff <= pfree_in; nfree_ff <= nfree_in; splice_ff <= splice_in;
      st_ff <= st_in;       raddr_ff <= raddr_in; rbw_ff <= rbw_in;
      wq_addr_ff <= wq_addr_in;
      wq_data_ff <= wq_data_in;
      if (load_out) begin
         o_status_ff <= st_ff;
         o_addr_ff   <= raddr_ff;
         o_bw_ff     <= rbw_ff;
         o_used_ff   <= alloc_ff;
         o_frag_ff   <= frag_ff;
         o_top_ff    <= top_ff;
      end
   end

   // stores: one write and one registered read per cycle each
   always_ff @(posedge clock) begin
      if (tag_we) begin
         tag_mem[tag_wa] <= tag_wd;
      end
      tag_rd_ff <= tag_mem[tag_ra];
   end

   always_ff @(posedge clock) begin
      if (next_we) begin
         next_mem[next_wa] <= next_wd;
      end
      next_rd_ff <= next_mem[next_ra];
   end

   always_ff @(posedge clock) begin
      if (prev_we) begin
         prev_mem[prev_wa] <= prev_wd;
      end
      prev_rd_ff <= prev_mem[prev_ra];
   end

   assign out_valid          = rsp_valid_ff;
   assign out_status         = o_status_ff;
   assign out_addr           = o_addr_ff;
   assign out_block_words    = o_bw_ff;
   assign out_used_words     = o_used_ff;
   assign out_free_fragments = o_frag_ff;
   assign out_high_mark      = o_top_ff;
endmodule
`default_nettype wire

// ----- rtl/boundary_tag_pool_allocator_unit.sv -----
// One transaction is in service at a time; the queue holds further requests meanwhile. An allocate
// walks the free-list entries in turn; a free may step back over list entries from the tail.
// A result held by rsp_tready low delays the start of the next transaction.
// Reset: synchronous; clears list head/tail, top mark, counters and handshakes.
// The stores are not cleared; there is no clearing pass after reset.
`default_nettype none
module boundary_tag_pool_allocator_unit #(
   parameter int MIN_BLOCK_WORDS = btpa_pkg::MIN_BLOCK_WORDS
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // request channel
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [31:0] req_tdata,   // [12:0] req_words, [24:13] free_addr, rest zero
   input  wire logic [0:0]  req_tuser,   // [0] action
   // result channel
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [63:0]      rsp_tdata,   // [11:0] addr, [24:12] block_words,
                                         // [37:25] used_words, [48:38] free_fragments,
                                         // [61:49] high_mark, rest zero
   output logic [1:0]       rsp_tuser,   // [1:0] status
   // configuration
   input  wire logic        csr_wr_en,
   input  wire logic [12:0] csr_wr_data  // pool_words
);
   logic [12:0]       pool_words_ff;
   logic              q_push, q_full, q_pop, q_valid;
   btpa_pkg::cmd_type f_cmd, q_cmd;
   logic [11:0]       o_addr;
   logic [12:0]       o_bw, o_used, o_top;
   logic [10:0]       o_frag;

   // pool size; software must write it only while no transaction is in flight; not enforced
   always_ff @(posedge clock) begin
      if (reset) begin
         pool_words_ff <= btpa_pkg::POOL_RESET;
      end else if (csr_wr_en) begin
         pool_words_ff <= csr_wr_data;
      end
   end

   // classify and queue each request transaction
   btpa_front #(.MIN_BLOCK_WORDS(MIN_BLOCK_WORDS)) u_front (
      .in_valid     (req_tvalid),
      .in_ready     (req_tready),
      .in_action    (req_tuser[0]),
      .in_req_words (req_tdata[12:0]),
      .in_free_addr (req_tdata[24:13]),
      .push         (q_push),
      .cmd          (f_cmd),
      .q_full       (q_full)
   );

   // decouple the front end from the engine
   btpa_queue #(.DEPTH(btpa_pkg::QUEUE_DEPTH)) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_cmd (f_cmd),
      .full     (q_full),
      .pop      (q_pop),
      .valid    (q_valid),
      .head_cmd (q_cmd)
   );

   // carry out allocate and free against the stores
   btpa_engine #(.MIN_BLOCK_WORDS(MIN_BLOCK_WORDS)) u_engine (
      .clock              (clock),
      .reset              (reset),
      .pool_words         (pool_words_ff),
      .q_valid            (q_valid),
      .q_cmd              (q_cmd),
      .pop                (q_pop),
      .out_valid          (rsp_tvalid),
      .out_ready          (rsp_tready),
      .out_status         (rsp_tuser),
      .out_addr           (o_addr),
      .out_block_words    (o_bw),
      .out_used_words     (o_used),
      .out_free_fragments (o_frag),
      .out_high_mark      (o_top)
   );

   assign rsp_tdata = {2'b00, o_top, o_frag, o_used, o_bw, o_addr};

   // a failed allocate or rejected free reports no block
   a_fail_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser != btpa_pkg::STAT_OK) |-> (o_addr == '0) && (o_bw == '0))
      else $error("failed transaction reports a block");

   // any block that was handed out or freed is at least the minimum size
   a_min_block: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == btpa_pkg::STAT_OK) && (o_bw != '0)
      |-> (o_bw >= 13'(MIN_BLOCK_WORDS)))
      else $error("block below minimum size");

   // the top mark never passes the store
   a_top_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (o_top <= btpa_pkg::POOL_RESET))
      else $error("top mark beyond store");
endmodule
`default_nettype wire

// ----- tb/boundary_tag_pool_allocator_unit_tb.sv -----
// Self-checking bench for boundary_tag_pool_allocator_unit: a shadow allocator predicts
// every allocate/free transaction under several pool sizes. Depends on rtl/btpa_pkg.sv.
// Stimulus is generated up front against the shadow state so no free reads an unwritten tag.
`default_nettype none
module boundary_tag_pool_allocator_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned NONE     = 32'hFFFF_FFFF;
   localparam int unsigned USED_BIT = 32'h8000_0000;
   localparam int unsigned SZ_MASK  = 32'h7FFF_FFFF;

   typedef struct {
      logic                        act;
      logic [btpa_pkg::SIZE_W-1:0] words;
      logic [btpa_pkg::ADDR_W-1:0] fa;
   } alloc_req_type;

   typedef struct {
      logic [1:0]                  status;
      logic [btpa_pkg::ADDR_W-1:0] addr;
      logic [btpa_pkg::SIZE_W-1:0] blk;
      logic [btpa_pkg::SIZE_W-1:0] used;
      logic [btpa_pkg::FRAG_W-1:0] frags;
      logic [btpa_pkg::SIZE_W-1:0] top;
   } alloc_rsp_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;   // [12:0] req_words, [24:13] free_addr
   logic [0:0]  req_tuser = '0;   // [0] action
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [63:0] rsp_tdata;        // [11:0] addr, [24:12] block_words, [37:25] used_words,
                                  // [48:38] free_fragments, [61:49] high_mark
   logic [1:0]  rsp_tuser;        // [1:0] status
   logic        csr_wr_en = 1'b0;
   logic [12:0] csr_wr_data = '0;

   boundary_tag_pool_allocator_unit dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data)
   );

   always #2 clock = ~clock;

   // ---------------------------------------------------------------------------
   // Shadow allocator: same store layout as the block, kept at 32 bits internally
   // so sizes past 4096 and the flag bit never alias.
   // ---------------------------------------------------------------------------
   int unsigned tag_word [btpa_pkg::POOL_WORDS];
   int unsigned link_next[btpa_pkg::POOL_WORDS];
   int unsigned link_prev[btpa_pkg::POOL_WORDS];
   bit          tag_known[btpa_pkg::POOL_WORDS];   // tag word written at least once
   int unsigned head_ptr = NONE, tail_ptr = NONE;
   int unsigned top_mark = 0, used_words = 0, frag_cnt = 0, pool_reg = btpa_pkg::POOL_RESET;

   alloc_req_type pending_reqs[$];
   alloc_rsp_type predicted_rsps[$];
   int unsigned   live_blocks[$];        // payload addresses believed allocated
   int            mismatches = 0;

   function automatic bit in_store(int unsigned i);
      return i < btpa_pkg::POOL_WORDS;
   endfunction

   function automatic void stamp_tags(int unsigned s, int unsigned sz, int unsigned flag);
      if (sz == 0) return;
      if (in_store(s)) begin
         tag_word[s] = sz | flag;
         tag_known[s] = 1'b1;
      end
      if (in_store(s + sz - 1)) begin
         tag_word[s + sz - 1] = sz | flag;
         tag_known[s + sz - 1] = 1'b1;
      end
   endfunction

   function automatic void point_next(int unsigned n, int unsigned v);
      if (in_store(n)) link_next[n] = v; else head_ptr = v;
   endfunction

   function automatic void point_prev(int unsigned n, int unsigned v);
      if (in_store(n)) link_prev[n] = v; else tail_ptr = v;
   endfunction

   function automatic void drop_fragment();
      if (frag_cnt > 0) frag_cnt--;
   endfunction

   function automatic void unlink_block(int unsigned n);
      if (!in_store(n)) return;
      point_next(link_prev[n], link_next[n]);
      point_prev(link_next[n], link_prev[n]);
   endfunction

   function automatic alloc_rsp_type snapshot(logic [1:0] st, int unsigned a, int unsigned bw);
      alloc_rsp_type r;
      r.status = st;
      r.addr   = a[btpa_pkg::ADDR_W-1:0];
      r.blk    = bw[btpa_pkg::SIZE_W-1:0];
      r.used   = used_words[btpa_pkg::SIZE_W-1:0];
      r.frags  = frag_cnt[btpa_pkg::FRAG_W-1:0];
      r.top    = top_mark[btpa_pkg::SIZE_W-1:0];
      return r;
   endfunction

   function automatic alloc_rsp_type predict_alloc(int unsigned req);
      int unsigned sz, lim, node, fsz, rest, s;
      sz   = req + 2;
      lim  = (pool_reg > btpa_pkg::POOL_WORDS) ? btpa_pkg::POOL_WORDS : pool_reg;
      node = head_ptr;
      if (sz < btpa_pkg::MIN_BLOCK_WORDS) sz = btpa_pkg::MIN_BLOCK_WORDS;
      // first fit over the address-ordered free list
      for (int unsigned k = 0; k < frag_cnt && in_store(node); k++) begin
         fsz = tag_word[node] & SZ_MASK;
         if (fsz >= sz) begin
            rest = fsz - sz;
            if (rest >= btpa_pkg::MIN_BLOCK_WORDS) begin
               stamp_tags(node, rest, 0);
               s = node + rest;
            end else begin
               sz = fsz;
               s  = node;
               unlink_block(node);
               drop_fragment();
            end
            used_words += sz;
            stamp_tags(s, sz, USED_BIT);
            return snapshot(btpa_pkg::STAT_OK, s + 1, sz);
         end
         node = link_next[node];
      end
      // bump the top mark
      if (top_mark <= lim && lim - top_mark >= sz) begin
         s = top_mark;
         top_mark += sz;
         used_words += sz;
         stamp_tags(s, sz, USED_BIT);
         return snapshot(btpa_pkg::STAT_OK, s + 1, sz);
      end
      return snapshot(btpa_pkg::STAT_NOSPACE, 0, 0);
   endfunction

   function automatic alloc_rsp_type predict_free(int unsigned fa);
      int unsigned s, tg, sz, endb, psz, nsz, merged, pt, nt, w, x;
      bit pfree, nfree;
      pfree = 0;
      nfree = 0;
      psz = 0;
      nsz = 0;
      if (fa < 1) return snapshot(btpa_pkg::STAT_BADFREE, 0, 0);
      s  = fa - 1;
      tg = tag_word[s];
      sz = tg & SZ_MASK;
      if (sz < btpa_pkg::MIN_BLOCK_WORDS || (tg & USED_BIT) == 0)
         return snapshot(btpa_pkg::STAT_BADFREE, 0, 0);
      if (s + sz > top_mark) return snapshot(btpa_pkg::STAT_BADFREE, 0, 0);
      endb = s + sz;
      if (tag_word[endb - 1] != tg) return snapshot(btpa_pkg::STAT_BADFREE, 0, 0);
      if (s > 0) begin
         pt    = tag_word[s - 1];
         psz   = pt & SZ_MASK;
         pfree = (pt & USED_BIT) == 0 && psz >= btpa_pkg::MIN_BLOCK_WORDS && psz <= s;
      end
      if (endb != top_mark) begin
         nt    = tag_word[endb];
         nsz   = nt & SZ_MASK;
         nfree = (nt & USED_BIT) == 0 && nsz >= btpa_pkg::MIN_BLOCK_WORDS
                 && nsz <= top_mark - endb;
      end
      used_words = (used_words >= sz) ? used_words - sz : 0;
      if (endb == top_mark) begin
         // end block: give the space back to the top, absorbing a free predecessor
         if (pfree) begin
            s -= psz;
            unlink_block(s);
            drop_fragment();
         end
         top_mark = s;
         return snapshot(btpa_pkg::STAT_OK, 0, sz);
      end
      merged = sz;
      if (pfree) begin
         s -= psz;
         merged += psz;
         if (nfree) begin
            merged += nsz;
            unlink_block(endb);
            drop_fragment();
         end
      end else if (nfree) begin
         merged += nsz;
         if (in_store(endb) && in_store(s)) begin
            link_next[s] = link_next[endb];
            link_prev[s] = link_prev[endb];
            point_next(link_prev[endb], s);
            point_prev(link_next[endb], s);
         end
      end else begin
         // walk back from the tail to keep the list in address order
         w = tail_ptr;
         for (int unsigned k = 0; k < btpa_pkg::POOL_WORDS && in_store(w) && w > s; k++)
            w = link_prev[w];
         x = in_store(w) ? link_next[w] : head_ptr;
         link_next[s] = x;
         link_prev[s] = in_store(w) ? w : NONE;
         point_next(w, s);
         point_prev(x, s);
         if (frag_cnt < btpa_pkg::FRAG_MAX) frag_cnt++;
      end
      stamp_tags(s, merged, 0);
      return snapshot(btpa_pkg::STAT_OK, 0, sz);
   endfunction

   // True when every tag word the free path would read has been written.
   function automatic bit free_reads_known(int unsigned fa);
      int unsigned s, tg, sz, endb;
      if (fa == 0) return 1;
      s = fa - 1;
      if (!tag_known[s]) return 0;
      tg = tag_word[s];
      sz = tg & SZ_MASK;
      if (sz < btpa_pkg::MIN_BLOCK_WORDS || (tg & USED_BIT) == 0 || s + sz > top_mark)
         return 1;
      endb = s + sz;
      if (!tag_known[endb - 1]) return 0;
      if (tag_word[endb - 1] != tg) return 1;
      if (s > 0 && !tag_known[s - 1]) return 0;
      if (endb != top_mark && !tag_known[endb]) return 0;
      return 1;
   endfunction

   // ---------------------------------------------------------------------------
   // Stimulus builders: queue the transaction and its predicted result together.
   // ---------------------------------------------------------------------------
   task automatic queue_alloc(int unsigned req);
      alloc_req_type t;
      alloc_rsp_type r;
      t.act   = btpa_pkg::ACT_ALLOC;
      t.words = req[btpa_pkg::SIZE_W-1:0];
      t.fa    = btpa_pkg::ADDR_W'($urandom);   // ignored by the block; toggle it anyway
      r = predict_alloc(req & 32'h1FFF);
      if (r.status == btpa_pkg::STAT_OK) live_blocks.push_back(r.addr);
      pending_reqs.push_back(t);
      predicted_rsps.push_back(r);
   endtask

   // Falls back to a known-live block, or to address zero, when the chosen
   // address would read tag words that were never written.
   task automatic queue_free(int unsigned fa);
      alloc_req_type t;
      alloc_rsp_type r;
      int            idx;
      if (!free_reads_known(fa)) begin
         fa = 0;
         if (live_blocks.size() > 0) begin
            idx = $urandom_range(0, live_blocks.size() - 1);
            if (free_reads_known(live_blocks[idx])) fa = live_blocks[idx];
         end
      end
      t.act   = btpa_pkg::ACT_FREE;
      t.words = btpa_pkg::SIZE_W'($urandom);
      t.fa    = fa[btpa_pkg::ADDR_W-1:0];
      r = predict_free(fa);
      if (r.status == btpa_pkg::STAT_OK)
         foreach (live_blocks[i])
            if (live_blocks[i] == fa) begin
               live_blocks.delete(i);
               break;
            end
      pending_reqs.push_back(t);
      predicted_rsps.push_back(r);
   endtask

   task automatic queue_random(int n);
      int unsigned r, req, fa, base;
      for (int i = 0; i < n; i++) begin
         r = $urandom_range(0, 99);
         if (live_blocks.size() < 3 || r < 52) begin
            r = $urandom_range(0, 99);
            if (r < 55)      req = $urandom_range(0, 30);
            else if (r < 82) req = $urandom_range(31, 300);
            else if (r < 92) req = $urandom_range(0, 3);
            else if (r < 97) req = $urandom_range(300, 4096);
            else             req = $urandom_range(0, 8191);
            queue_alloc(req);
         end else begin
            r = $urandom_range(0, 99);
            base = live_blocks[$urandom_range(0, live_blocks.size() - 1)];
            if (r < 75)      fa = base;                                  // well-formed
            else if (r < 85) fa = (base + $urandom_range(0, 6)) % btpa_pkg::POOL_WORDS;
            else if (r < 95) fa = $urandom_range(0, btpa_pkg::POOL_WORDS - 1);
            else             fa = 0;
            queue_free(fa);
         end
      end
   endtask

   // ---------------------------------------------------------------------------
   // Driver: bursts of transactions separated by random gaps; valid holds until
   // the transaction is taken.
   // ---------------------------------------------------------------------------
   int burst_left = 8;
   int gap_left   = 0;

   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            pending_reqs.delete(0);
            burst_left--;
            if (burst_left <= 0) begin
               burst_left = $urandom_range(1, 20);
               gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
            end
            if (gap_left > 0 || pending_reqs.size() == 0) begin
               req_tvalid <= 1'b0;
            end else begin
               req_tvalid <= 1'b1;
               req_tdata  <= {7'd0, pending_reqs[0].fa, pending_reqs[0].words};
               req_tuser  <= pending_reqs[0].act;
            end
         end else if (req_tvalid) begin
            // hold the offered transaction
         end else if (gap_left > 0) begin
            gap_left--;
         end else if (pending_reqs.size() > 0) begin
            req_tvalid <= 1'b1;
            req_tdata  <= {7'd0, pending_reqs[0].fa, pending_reqs[0].words};
            req_tuser  <= pending_reqs[0].act;
         end
      end
   end

   // ---------------------------------------------------------------------------
   // Monitor: ready follows its own pattern (always on, random, periodic), and
   // every accepted result is checked against the oldest prediction.
   // ---------------------------------------------------------------------------
   int stall_mode = 0;
   int mode_left  = 200;
   int beat       = 0;

   always @(posedge clock) begin
      alloc_rsp_type e;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (predicted_rsps.size() == 0) begin
               $error("result with no transaction outstanding");
               mismatches++;
            end else begin
               e = predicted_rsps.pop_front();
               if (rsp_tuser != e.status) begin
                  $error("status expected %0d got %0d", e.status, rsp_tuser);
                  mismatches++;
               end
               if (rsp_tdata[11:0] != e.addr) begin
                  $error("addr expected %0d got %0d", e.addr, rsp_tdata[11:0]);
                  mismatches++;
               end
               if (rsp_tdata[24:12] != e.blk) begin
                  $error("block_words expected %0d got %0d", e.blk, rsp_tdata[24:12]);
                  mismatches++;
               end
               if (rsp_tdata[37:25] != e.used) begin
                  $error("used_words expected %0d got %0d", e.used, rsp_tdata[37:25]);
                  mismatches++;
               end
               if (rsp_tdata[48:38] != e.frags) begin
                  $error("free_fragments expected %0d got %0d", e.frags, rsp_tdata[48:38]);
                  mismatches++;
               end
               if (rsp_tdata[61:49] != e.top) begin
                  $error("high_mark expected %0d got %0d", e.top, rsp_tdata[61:49]);
                  mismatches++;
               end
            end
         end
         mode_left--;
         if (mode_left <= 0) begin
            stall_mode = $urandom_range(0, 2);
            mode_left  = $urandom_range(50, 400);
         end
         beat++;
         case (stall_mode)
            0: rsp_tready <= 1'b1;
            1: rsp_tready <= ($urandom_range(0, 1) == 1);
            default: rsp_tready <= (beat % 7) < 3;
         endcase
      end
   end

   // ---------------------------------------------------------------------------
   // Sequence: reset, directed cases, then random phases under different pool
   // sizes. The pool register changes only once the block has drained.
   // ---------------------------------------------------------------------------
   task automatic wait_drained();
      while (pending_reqs.size() != 0 || predicted_rsps.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   task automatic write_pool(int unsigned v);
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v[12:0];
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      pool_reg = v & 32'h1FFF;
   endtask

   int unsigned pool_steps[6] = '{8191, 300, 8, 64, 1000, 4096};

   initial begin
      int unsigned a0, a1, a2;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // directed: size floor, tag overhead, oversize requests, bad frees,
      // coalescing, split on reuse, end-block free lowering the top mark
      queue_alloc(0);
      queue_alloc(1);
      queue_alloc(2);
      queue_alloc(8191);
      queue_alloc(4096);
      queue_alloc(20);
      queue_alloc(20);
      queue_alloc(20);
      a0 = live_blocks[3];
      a1 = live_blocks[4];
      a2 = live_blocks[5];
      queue_free(0);
      queue_free(a1);
      queue_free(a1);               // double free
      queue_free(a0);               // merge with free successor
      queue_free(a0 + 2);           // aimed inside a free block
      queue_alloc(5);               // split the merged fragment
      queue_free(1);                // first block, no predecessor
      queue_alloc(4094);            // fails: no room left
      queue_free(a2);               // end block
      queue_alloc(4000);            // bump to near the end of the pool
      queue_free(4095);             // unwritten tags fall back to a live block
      queue_alloc(3);
      queue_free(live_blocks[live_blocks.size() - 1]);

      queue_random(150);
      foreach (pool_steps[i]) begin
         wait_drained();
         write_pool(pool_steps[i]);
         queue_random(125);
      end

      wait_drained();
      repeat (200) @(posedge clock);
      if (mismatches == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

   initial begin
      #100ms;
      $display("end of test: mismatches");
      $finish;
   end
endmodule
`default_nettype wire

// ----- boundary_tag_pool_allocator_unit.f -----
rtl/btpa_pkg.sv
rtl/btpa_front.sv
rtl/btpa_queue.sv
rtl/btpa_engine.sv
rtl/boundary_tag_pool_allocator_unit.sv
tb/boundary_tag_pool_allocator_unit_tb.sv
